// ===== rtl/core/mbet_pkg.sv =====
package mbet_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 28;

    localparam int ITER_W     = 16;
    localparam int ESC_CNT_W  = 24;
    localparam int ESC_SUM_W  = 40;
    localparam int M_FIELDS_W = 3 * ITER_W + 1 + ESC_CNT_W + ESC_SUM_W + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

    localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(1000);

    typedef struct packed {
        logic [ITER_W-1:0] count;
        logic              in_set;
    } mbet_result_t;

endpackage

// ===== rtl/core/mbet_core.sv =====
module mbet_core #(
    parameter int COORD_WIDTH = mbet_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = mbet_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [COORD_WIDTH-1:0]      c_real,
    input  logic signed [COORD_WIDTH-1:0]      c_imag,
    input  logic        [mbet_pkg::ITER_W-1:0] max_iter,
    output logic                               ready,
    output logic                               res_valid,
    input  logic                               res_ready,
    output mbet_pkg::mbet_result_t             res
);

    localparam int MAG_W  = FRAC_BITS + 2;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SQ_W   = PROD_W - FRAC_BITS;
    localparam int X_W    = PROD_W - FRAC_BITS + 1;
    localparam int TERM_W = FRAC_BITS + 5;
    localparam int SUM_W  = ((COORD_WIDTH > TERM_W) ? COORD_WIDTH : TERM_W) + 1;
    localparam int Z_W    = (SUM_W > 64) ? 64 : SUM_W;
    localparam int ITER_W = mbet_pkg::ITER_W;

    localparam logic signed [SUM_W-1:0] Z_MAX = (SUM_W'(1) <<< (Z_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] Z_MIN = -Z_MAX - SUM_W'(1);
    localparam logic [Z_W-1:0]          MAG_LIM = Z_W'(1) << (FRAC_BITS + 1);
    localparam logic [PROD_W:0]         ESC_LIM = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_SQ_RE,
        S_SQ_IM,
        S_CROSS,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic signed [COORD_WIDTH-1:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [Z_W-1:0]    re_reg, re_next, im_reg, im_next;
    logic [PROD_W-1:0]        sq_re_reg, sq_re_next, sq_im_reg, sq_im_next;
    logic [PROD_W-1:0]        cross_reg, cross_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic [ITER_W-1:0]        count_reg, count_next;
    logic                     inside_reg, inside_next;

    logic [Z_W-1:0]           mag_re, mag_im;
    logic                     big;
    logic [MAG_W-1:0]         op_a, op_b;
    logic [PROD_W-1:0]        prod;
    logic [PROD_W:0]          mag_sq;
    logic                     escape_now;

    logic signed [SUM_W-1:0]  sqr_ext, sqi_ext, x_ext, x_signed, cr_ext, ci_ext;
    logic signed [SUM_W-1:0]  re_sum, im_sum;
    logic signed [Z_W-1:0]    re_sat, im_sat;

    assign mag_re = re_reg[Z_W-1] ? Z_W'(-re_reg) : Z_W'(re_reg);
    assign mag_im = im_reg[Z_W-1] ? Z_W'(-im_reg) : Z_W'(im_reg);
    assign big    = (mag_re > MAG_LIM) || (mag_im > MAG_LIM);

    always_comb begin
        unique case (state_reg)
            S_SQ_RE: begin
                op_a = mag_re[MAG_W-1:0];
                op_b = mag_re[MAG_W-1:0];
            end
            S_SQ_IM: begin
                op_a = mag_im[MAG_W-1:0];
                op_b = mag_im[MAG_W-1:0];
            end
            default: begin
                op_a = mag_re[MAG_W-1:0];
                op_b = mag_im[MAG_W-1:0];
            end
        endcase
    end

    assign prod       = op_a * op_b;
    assign mag_sq     = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    assign escape_now = mag_sq > ESC_LIM;

    assign sqr_ext  = {{(SUM_W - SQ_W){1'b0}}, sq_re_reg[PROD_W-1:FRAC_BITS]};
    assign sqi_ext  = {{(SUM_W - SQ_W){1'b0}}, sq_im_reg[PROD_W-1:FRAC_BITS]};
    assign x_ext    = {{(SUM_W - X_W){1'b0}}, cross_reg[PROD_W-1:FRAC_BITS-1]};
    assign x_signed = (re_reg[Z_W-1] != im_reg[Z_W-1]) ? -x_ext : x_ext;
    assign cr_ext   = {{(SUM_W - COORD_WIDTH){cr_reg[COORD_WIDTH-1]}}, cr_reg};
    assign ci_ext   = {{(SUM_W - COORD_WIDTH){ci_reg[COORD_WIDTH-1]}}, ci_reg};
    assign re_sum   = sqr_ext - sqi_ext + cr_ext;
    assign im_sum   = x_signed + ci_ext;

    assign re_sat = (re_sum > Z_MAX) ? Z_MAX[Z_W-1:0] :
                    (re_sum < Z_MIN) ? Z_MIN[Z_W-1:0] : re_sum[Z_W-1:0];
    assign im_sat = (im_sum > Z_MAX) ? Z_MAX[Z_W-1:0] :
                    (im_sum < Z_MIN) ? Z_MIN[Z_W-1:0] : im_sum[Z_W-1:0];

    always_comb begin
        state_next  = state_reg;
        cr_next     = cr_reg;
        ci_next     = ci_reg;
        re_next     = re_reg;
        im_next     = im_reg;
        sq_re_next  = sq_re_reg;
        sq_im_next  = sq_im_reg;
        cross_next  = cross_reg;
        iter_next   = iter_reg;
        count_next  = count_reg;
        inside_next = inside_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cr_next    = c_real;
                    ci_next    = c_imag;
                    re_next    = '0;
                    im_next    = '0;
                    sq_re_next = '0;
                    sq_im_next = '0;
                    cross_next = '0;
                    iter_next  = '0;
                    if (max_iter == '0) begin
                        count_next  = '0;
                        inside_next = 1'b1;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                re_next    = re_sat;
                im_next    = im_sat;
                state_next = S_SQ_RE;
            end
            S_SQ_RE: begin
                if (big) begin
                    count_next  = iter_reg;
                    inside_next = 1'b0;
                    state_next  = S_DONE;
                end else begin
                    sq_re_next = prod;
                    state_next = S_SQ_IM;
                end
            end
            S_SQ_IM: begin
                sq_im_next = prod;
                state_next = S_CROSS;
            end
            S_CROSS: begin
                if (escape_now) begin
                    count_next  = iter_reg;
                    inside_next = 1'b0;
                    state_next  = S_DONE;
                end else if (iter_reg == max_iter - ITER_W'(1)) begin
                    count_next  = max_iter;
                    inside_next = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    cross_next = prod;
                    iter_next  = iter_reg + ITER_W'(1);
                    state_next = S_UPDATE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        re_reg     <= re_next;
        im_reg     <= im_next;
        sq_re_reg  <= sq_re_next;
        sq_im_reg  <= sq_im_next;
        cross_reg  <= cross_next;
        iter_reg   <= iter_next;
        count_reg  <= count_next;
        inside_reg <= inside_next;
    end

    assign ready      = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.count  = count_reg;
    assign res.in_set = inside_reg;

endmodule

// ===== rtl/core/mandelbrot_escape_time.sv =====
// Escape-time unit: one point at a time on a shared multiplier; each iteration steps through
// the z update, re squared with a bound test on |re| and |im|, im squared, and the cross
// product with the escape compare. A new point is accepted only after the previous result
// has transferred and the core is back in idle; no new point is taken while one is in flight.
// Reset (aresetn low, synchronous): idle, no result, max_iterations 1000, frame stats cleared.
module mandelbrot_escape_time #(
    parameter int COORD_WIDTH = mbet_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = mbet_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // c_real, c_imag
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    // frame_start
    input  logic                                  s_tuser,

    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // escape_count, in_set, min_escape, max_escape, escaped_points, escape_sum, none_escaped
    output logic [mbet_pkg::M_DATA_W-1:0]         m_tdata,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mbet_pkg::ITER_W-1:0]           cfg_data
);

    localparam int ITER_W = mbet_pkg::ITER_W;
    localparam int CNT_W  = mbet_pkg::ESC_CNT_W;
    localparam int SUM_W  = mbet_pkg::ESC_SUM_W;

    logic [ITER_W-1:0]            max_iter_reg;
    logic [ITER_W-1:0]            fmin_reg, fmin_next;
    logic [ITER_W-1:0]            fmax_reg, fmax_next;
    logic [CNT_W-1:0]             fcnt_reg, fcnt_next;
    logic [SUM_W-1:0]             fsum_reg, fsum_next;
    logic                         fnone_reg, fnone_next;
    logic                         m_valid_reg;
    logic [mbet_pkg::M_DATA_W-1:0] m_data_reg;

    logic                         s_xfer;
    logic                         core_ready;
    logic                         res_valid, res_ready, res_xfer;
    mbet_pkg::mbet_result_t       res;
    logic [SUM_W:0]               sum_wide;

    assign s_tready  = core_ready;
    assign s_xfer    = s_tvalid && core_ready;
    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_tready;
    assign res_xfer  = res_valid && res_ready;

    mbet_core #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_xfer),
        .c_real    (s_tdata[COORD_WIDTH-1:0]),
        .c_imag    (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .max_iter  (max_iter_reg),
        .ready     (core_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign sum_wide = {1'b0, fsum_reg} + (SUM_W + 1)'(res.count);

    always_comb begin
        fmin_next  = fmin_reg;
        fmax_next  = fmax_reg;
        fcnt_next  = fcnt_reg;
        fsum_next  = fsum_reg;
        fnone_next = fnone_reg;
        if (s_xfer && s_tuser) begin
            fmin_next  = max_iter_reg;
            fmax_next  = '0;
            fcnt_next  = '0;
            fsum_next  = '0;
            fnone_next = 1'b1;
        end else if (res_xfer && !res.in_set) begin
            if (res.count < fmin_reg) begin
                fmin_next = res.count;
            end
            if (res.count > fmax_reg) begin
                fmax_next = res.count;
            end
            if (fcnt_reg != '1) begin
                fcnt_next = fcnt_reg + CNT_W'(1);
            end
            fsum_next  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            fnone_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= mbet_pkg::ITER_RESET;
            fmin_reg     <= mbet_pkg::ITER_RESET;
            fmax_reg     <= '0;
            fcnt_reg     <= '0;
            fsum_reg     <= '0;
            fnone_reg    <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_iter_reg <= cfg_data;
            end
            fmin_reg  <= fmin_next;
            fmax_reg  <= fmax_next;
            fcnt_reg  <= fcnt_next;
            fsum_reg  <= fsum_next;
            fnone_reg <= fnone_next;
            if (res_xfer) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (res_xfer) begin
            m_data_reg <= {{mbet_pkg::M_PAD_W{1'b0}}, fnone_next, fsum_next, fcnt_next,
                           fmax_next, fmin_next, res.in_set, res.count};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
